[sv/rlso_pkg.sv]
// ----------------------------------------------------------------------------
// rlso_pkg
// Types and constants shared by the language-set operation unit and its testbench.
// ----------------------------------------------------------------------------
package rlso_pkg;

  // Width of a full language set as carried on the ports (two 64-bit words).
  localparam int unsigned SET_W = 128;
  // Width of one infix index.
  localparam int unsigned IDX_W = 7;

  // Request codes.
  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_OPT   = 3'd1;
  localparam logic [2:0] REQ_STAR  = 3'd2;
  localparam logic [2:0] REQ_CAT   = 3'd3;
  localparam logic [2:0] REQ_UNION = 3'd4;
  localparam logic [2:0] REQ_INTER = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ALPHABET_SIZE = 3'd0;
  localparam logic [2:0] CFG_INFIX_COUNT   = 3'd1;
  localparam logic [2:0] CFG_POSITIVE_LOW  = 3'd2;
  localparam logic [2:0] CFG_POSITIVE_HIGH = 3'd3;
  localparam logic [2:0] CFG_NEGATIVE_LOW  = 3'd4;
  localparam logic [2:0] CFG_NEGATIVE_HIGH = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] set_a_low;
    logic [63:0] set_a_high;
    logic [63:0] set_b_low;
    logic [63:0] set_b_high;
    logic [6:0]  row_index;
    logic [3:0]  split_slot;
    logic [6:0]  prefix_index;
    logic [6:0]  suffix_index;
  } req_item_t;

  typedef struct packed {
    logic [63:0] result_a_low;
    logic [63:0] result_a_high;
    logic [63:0] result_b_low;
    logic [63:0] result_b_high;
    logic        fits_a;
    logic        fits_b;
  } res_item_t;

  // Mask that keeps the lowest 'bits' bits of a full-width set.
  function automatic logic [SET_W-1:0] set_mask(int unsigned bits);
    logic [SET_W-1:0] m;
    for (int unsigned k = 0; k < SET_W; k++) begin
      m[k] = (k < bits);
    end
    return m;
  endfunction

endpackage

[sv/rlso_ram.sv]
// ----------------------------------------------------------------------------
// rlso_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlso_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/regex_language_set_ops_unit.sv]
// ----------------------------------------------------------------------------
// regex_language_set_ops_unit
// Set operations on language bit vectors, with a guide table of infix splits.
// ----------------------------------------------------------------------------
// Usage. An item is taken at a rising edge where start is high and busy is
// low. A load item writes one split pair of an infix row into the guide
// table; it produces no result and keeps busy high for one cycle while the
// row is read, patched and written back. Optional, union and intersection
// keep busy high for one cycle and put their result on result_o, marked by
// result_valid_o, from the result register. Star and concatenate walk
// the infix rows from alphabet_size+1 up to min(infix_count, SET_BITS)-1,
// one row per cycle: each row is one word of the guide RAM holding all of
// its splits. The result then passes through the finishing state too.
// The RAM's read port is the pacing element; the next row is fetched while
// the current one is merged into the running set.
// Each result is present for exactly one cycle; the receiver cannot stall
// it, and a new item may be started in the cycle the result is shown.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready; the
// user must write it only while the unit is idle, which the unit itself does
// not enforce. Reset clears the control and configuration registers and the
// per-row valid bits, so every row count reads as zero; the split RAM itself
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module regex_language_set_ops_unit #(
  parameter int unsigned SET_BITS   = 128,
  parameter int unsigned MAX_SPLITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rlso_pkg::req_item_t  req_i,
  output logic                 result_valid_o,
  output rlso_pkg::res_item_t  result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int unsigned SW     = rlso_pkg::SET_W;
  localparam int unsigned IW     = rlso_pkg::IDX_W;
  localparam int unsigned AW     = $clog2(SET_BITS);
  localparam int unsigned CW     = $clog2(MAX_SPLITS + 1);
  localparam int unsigned PAIRS  = MAX_SPLITS * IW;
  localparam int unsigned WORD_W = CW + 2 * PAIRS;
  localparam logic [SW-1:0] MASK = rlso_pkg::set_mask(SET_BITS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_WALK = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [6:0]  alpha_q;
  logic [7:0]  infix_q;
  logic [63:0] pos_lo_q, pos_hi_q, neg_lo_q, neg_hi_q;

  // Item registers.
  logic [2:0]    req_q, req_d;
  logic [SW-1:0] a_q, a_d, b_q, b_d, ra_q, ra_d, rb_q, rb_d;
  logic [7:0]    ix_q, ix_d;
  logic          two_q, two_d;
  logic [6:0]    ld_row_q;
  logic [3:0]    ld_slot_q;
  logic [6:0]    ld_pre_q, ld_suf_q;
  logic [SET_BITS-1:0] row_vld_q;

  logic                  res_vld_q, res_vld_d;
  rlso_pkg::res_item_t   res_q, res_d;

  // RAM interface.
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata, ram_wdata;

  logic          accept;
  logic [SW-1:0] a_in, b_in, pos_m, neg_m;
  logic [7:0]    lim, first_ix, ix_inc;
  logic          load_ok;
  logic [CW-1:0] row_cnt;
  logic          hit_a, hit_b;
  logic [SW-1:0] x_set, y_set;
  logic          fit_a, fit_b;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign a_in  = {req_i.set_a_high, req_i.set_a_low} & MASK;
  assign b_in  = {req_i.set_b_high, req_i.set_b_low} & MASK;
  assign pos_m = {pos_hi_q, pos_lo_q} & MASK;
  assign neg_m = {neg_hi_q, neg_lo_q} & MASK;

  // Rows at or above the set width are never walked.
  assign lim      = (infix_q > 8'(SET_BITS)) ? 8'(SET_BITS) : infix_q;
  assign first_ix = {1'b0, alpha_q} + 8'd1;
  assign ix_inc   = ix_q + 8'd1;

  assign load_ok = ({1'b0, req_i.row_index} < 8'(SET_BITS)) &&
                   ({1'b0, req_i.split_slot} < 5'(MAX_SPLITS));

  // The row count of a row never loaded since reset reads as zero.
  assign row_cnt = row_vld_q[ix_q[AW-1:0]] ? ram_rdata[WORD_W-1 -: CW] : '0;

  // Star joins the running set with itself; concatenate joins A with B.
  assign x_set = (req_q == rlso_pkg::REQ_STAR) ? ra_q : a_q;
  assign y_set = (req_q == rlso_pkg::REQ_STAR) ? ra_q : b_q;

  always_comb begin
    logic [IW-1:0] p, s;
    logic          act;
    hit_a = 1'b0;
    hit_b = 1'b0;
    for (int unsigned j = 0; j < MAX_SPLITS; j++) begin
      p     = ram_rdata[j*IW +: IW];
      s     = ram_rdata[PAIRS + j*IW +: IW];
      act   = (CW'(j) < row_cnt);
      hit_a = hit_a | (act & x_set[p] & y_set[s]);
      hit_b = hit_b | (act & b_q[p] & a_q[s]);
    end
  end

  // Patch one split slot of the row read back from the RAM.
  always_comb begin
    ram_wdata = ram_rdata;
    for (int unsigned j = 0; j < MAX_SPLITS; j++) begin
      if (5'(j) == {1'b0, ld_slot_q}) begin
        ram_wdata[j*IW +: IW]         = ld_pre_q;
        ram_wdata[PAIRS + j*IW +: IW] = ld_suf_q;
      end
    end
    ram_wdata[WORD_W-1 -: CW] = CW'({1'b0, ld_slot_q} + 5'd1);
  end

  assign fit_a = ((ra_q & pos_m) == pos_m) && ((ra_q & neg_m) == '0);
  assign fit_b = ((rb_q & pos_m) == pos_m) && ((rb_q & neg_m) == '0);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    a_d       = a_q;
    b_d       = b_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    ix_d      = ix_q;
    two_d     = two_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = ix_inc[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        ram_raddr = (req_i.req_type == rlso_pkg::REQ_LOAD) ?
                    req_i.row_index[AW-1:0] : first_ix[AW-1:0];
        if (accept) begin
          req_d = req_i.req_type;
          a_d   = a_in;
          b_d   = b_in;
          ix_d  = first_ix;
          rb_d  = '0;
          two_d = 1'b0;
          case (req_i.req_type)
            rlso_pkg::REQ_LOAD: begin
              if (load_ok) begin
                state_d = ST_LOAD;
              end
            end
            rlso_pkg::REQ_OPT: begin
              ra_d    = a_in | SW'(1);
              state_d = ST_FIN;
            end
            rlso_pkg::REQ_STAR: begin
              ra_d    = a_in | SW'(1);
              state_d = (first_ix < lim) ? ST_WALK : ST_FIN;
            end
            rlso_pkg::REQ_CAT: begin
              ra_d    = (a_in[0] ? b_in : '0) | (b_in[0] ? a_in : '0);
              rb_d    = ra_d;
              two_d   = 1'b1;
              state_d = (first_ix < lim) ? ST_WALK : ST_FIN;
            end
            rlso_pkg::REQ_UNION: begin
              ra_d    = a_in | b_in;
              state_d = ST_FIN;
            end
            rlso_pkg::REQ_INTER: begin
              ra_d    = a_in & b_in;
              state_d = ST_FIN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_LOAD: begin
        ram_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        ra_d[ix_q[IW-1:0]] = ra_q[ix_q[IW-1:0]] | hit_a;
        if (two_q) begin
          rb_d[ix_q[IW-1:0]] = rb_q[ix_q[IW-1:0]] | hit_b;
        end
        ix_d = ix_inc;
        if (ix_inc >= lim) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        res_d.result_a_low  = ra_q[63:0];
        res_d.result_a_high = ra_q[127:64];
        res_d.result_b_low  = rb_q[63:0];
        res_d.result_b_high = rb_q[127:64];
        res_d.fits_a        = fit_a;
        res_d.fits_b        = two_q && fit_b;
        res_vld_d           = 1'b1;
        state_d             = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_vld_q <= 1'b0;
      row_vld_q <= '0;
      alpha_q   <= '0;
      infix_q   <= '0;
      pos_lo_q  <= '0;
      pos_hi_q  <= '0;
      neg_lo_q  <= '0;
      neg_hi_q  <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      if (ram_we) begin
        row_vld_q[ld_row_q[AW-1:0]] <= 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rlso_pkg::CFG_ALPHABET_SIZE: alpha_q  <= cfg_data_i[6:0];
          rlso_pkg::CFG_INFIX_COUNT:   infix_q  <= cfg_data_i[7:0];
          rlso_pkg::CFG_POSITIVE_LOW:  pos_lo_q <= cfg_data_i;
          rlso_pkg::CFG_POSITIVE_HIGH: pos_hi_q <= cfg_data_i;
          rlso_pkg::CFG_NEGATIVE_LOW:  neg_lo_q <= cfg_data_i;
          rlso_pkg::CFG_NEGATIVE_HIGH: neg_hi_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    a_q   <= a_d;
    b_q   <= b_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
    ix_q  <= ix_d;
    two_q <= two_d;
    res_q <= res_d;
    if (accept) begin
      ld_row_q  <= req_i.row_index;
      ld_slot_q <= req_i.split_slot;
      ld_pre_q  <= req_i.prefix_index;
      ld_suf_q  <= req_i.suffix_index;
    end
  end

  // Guide table: one word per infix row holding its count and all splits.
  rlso_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SET_BITS)
  ) u_split_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ld_row_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // A result strobe is produced only by the finishing state, and always by it.
  a_fin_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |=> result_valid_o)
    else $error("finishing state did not strobe a result");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_FIN))
    else $error("result strobe without a finishing state");

  // The row walk never reaches a row at or above the limit.
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> ix_q < lim)
    else $error("row walk beyond the infix limit");

  // The guide RAM is written only by a load, in the cycle after it was taken.
  a_write_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(accept) && $past(req_i.req_type == rlso_pkg::REQ_LOAD))
    else $error("guide table written outside a load");

endmodule

[tb/sv/regex_language_set_ops_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_language_set_ops_unit_tb
// Self-checking bench for the language-set operation unit. A behavioral
// predictor keeps its own guide table and register copies, computes each
// operation's result sets and fit flags at the input transfer, and a monitor
// compares every result strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module regex_language_set_ops_unit_tb;

  // Request codes the unit must ignore: no result, no state change.
  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  localparam int unsigned NUM_ROWS       = 128;
  localparam int unsigned NUM_SLOTS      = 16;
  // The watchdog allows many times the length of a full walk.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // A load holds busy for one cycle and an ignored request for none.
  localparam int unsigned SETTLE_CYCLES  = 4;
  // Quiet time at the end, longer than the slowest walk.
  localparam int unsigned DRAIN_CYCLES   = 140;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  rlso_pkg::req_item_t req_i;
  logic                result_valid_o;
  rlso_pkg::res_item_t result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i;
  logic [63:0]         cfg_data_i;

  regex_language_set_ops_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the guide table as the unit holds it.
  // --------------------------------------------------------------------------
  int unsigned cfg_alpha  = 0;
  int unsigned cfg_icount = 0;
  bit [127:0]  cfg_pos    = '0;
  bit [127:0]  cfg_neg    = '0;
  bit [6:0]    tbl_prefix [NUM_ROWS][NUM_SLOTS];
  bit [6:0]    tbl_suffix [NUM_ROWS][NUM_SLOTS];
  int unsigned tbl_count  [NUM_ROWS];

  // Stimulus bookkeeping: number of slots of each row written so far. Loads
  // only ever overwrite a written slot or append the next one, so the written
  // slots of a row always form an unbroken run from slot 0 and the row count
  // never covers a slot that holds nothing.
  int unsigned slots_filled [NUM_ROWS];

  rlso_pkg::res_item_t expected_results [$];
  int unsigned error_count  = 0;
  int unsigned idle_pct     = 11;
  int unsigned quiet_cycles = 0;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endfunction

  // True when some split (p, q) of the row has p in x and q in y.
  function automatic bit split_joins(int unsigned row, bit [127:0] x, bit [127:0] y);
    for (int unsigned j = 0; j < tbl_count[row]; j++) begin
      if (x[tbl_prefix[row][j]] && y[tbl_suffix[row][j]]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // A result fits when it holds every positive example and no negative one.
  function automatic bit covers_examples(bit [127:0] s);
    return ((s & cfg_pos) == cfg_pos) && ((s & cfg_neg) == '0);
  endfunction

  // Applies one accepted request to the predictor and queues its result.
  function automatic void apply_request(rlso_pkg::req_item_t it);
    bit [127:0]          a;
    bit [127:0]          b;
    bit [127:0]          ra;
    bit [127:0]          rb;
    int unsigned         walk_end;
    rlso_pkg::res_item_t r;
    a = {it.set_a_high, it.set_a_low};
    b = {it.set_b_high, it.set_b_low};
    ra = '0;
    rb = '0;
    // An infix count beyond the set width walks every row.
    walk_end = (cfg_icount > NUM_ROWS) ? NUM_ROWS : cfg_icount;
    case (it.req_type)
      rlso_pkg::REQ_LOAD: begin
        tbl_prefix[it.row_index][it.split_slot] = it.prefix_index;
        tbl_suffix[it.row_index][it.split_slot] = it.suffix_index;
        tbl_count[it.row_index] = 32'(it.split_slot) + 32'd1;
        return;
      end
      rlso_pkg::REQ_OPT: begin
        ra = a | 128'd1;
      end
      rlso_pkg::REQ_STAR: begin
        // Rows are taken in rising order, and a row joined earlier in the
        // same pass already counts as a part for the rows above it.
        ra = a | 128'd1;
        for (int unsigned ix = cfg_alpha + 1; ix < walk_end; ix++) begin
          if (!ra[ix] && split_joins(ix, ra, ra)) begin
            ra[ix] = 1'b1;
          end
        end
      end
      rlso_pkg::REQ_CAT: begin
        // The empty word on either side passes the other operand through.
        if (a[0]) ra |= b;
        if (b[0]) ra |= a;
        rb = ra;
        for (int unsigned ix = cfg_alpha + 1; ix < walk_end; ix++) begin
          if (!ra[ix] && split_joins(ix, a, b)) ra[ix] = 1'b1;
          if (!rb[ix] && split_joins(ix, b, a)) rb[ix] = 1'b1;
        end
      end
      rlso_pkg::REQ_UNION: begin
        ra = a | b;
      end
      rlso_pkg::REQ_INTER: begin
        ra = a & b;
      end
      default: begin
        return;
      end
    endcase
    r.result_a_low  = ra[63:0];
    r.result_a_high = ra[127:64];
    r.result_b_low  = rb[63:0];
    r.result_b_high = rb[127:64];
    r.fits_a        = covers_examples(ra);
    r.fits_b        = (it.req_type == rlso_pkg::REQ_CAT) && covers_examples(rb);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. The strobe lasts one cycle and cannot be stalled, so every
  // cycle with result_valid_o high is one result transfer.
  // --------------------------------------------------------------------------
  function automatic void check_result(rlso_pkg::res_item_t got);
    rlso_pkg::res_item_t want;
    string               bad;
    if (expected_results.size() == 0) begin
      flag_error($sformatf("result with nothing pending: a=%h_%h b=%h_%h fits=%b%b",
                           got.result_a_high, got.result_a_low, got.result_b_high,
                           got.result_b_low, got.fits_a, got.fits_b));
      return;
    end
    want = expected_results.pop_front();
    bad = "";
    if (got.result_a_low  !== want.result_a_low)  bad = {bad, " result_a_low"};
    if (got.result_a_high !== want.result_a_high) bad = {bad, " result_a_high"};
    if (got.result_b_low  !== want.result_b_low)  bad = {bad, " result_b_low"};
    if (got.result_b_high !== want.result_b_high) bad = {bad, " result_b_high"};
    if (got.fits_a        !== want.fits_a)        bad = {bad, " fits_a"};
    if (got.fits_b        !== want.fits_b)        bad = {bad, " fits_b"};
    if (bad != "") begin
      flag_error($sformatf({"fields%s\n  expected a=%h_%h b=%h_%h fits=%b%b",
                            "\n  actual   a=%h_%h b=%h_%h fits=%b%b"}, bad,
                           want.result_a_high, want.result_a_low, want.result_b_high,
                           want.result_b_low, want.fits_a, want.fits_b,
                           got.result_a_high, got.result_a_low, got.result_b_high,
                           got.result_b_low, got.fits_a, got.fits_b));
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      check_result(result_o);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL regex_language_set_ops_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Random set: empty, full, dense, or a few bits mostly near the bottom where
  // the single-character rows and short infixes live.
  function automatic bit [127:0] random_set();
    bit [127:0] s;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = '1;
      2, 3:    s = {$urandom, $urandom, $urandom, $urandom};
      default: begin
        s = '0;
        repeat ($urandom_range(1, 8)) begin
          s[$urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom_range(0, 127)] = 1'b1;
        end
      end
    endcase
    if ($urandom_range(0, 3) == 0) s[0] = ~s[0];
    return s;
  endfunction

  function automatic bit [127:0] sparse_bits(int unsigned lo, int unsigned hi,
                                             int unsigned n);
    bit [127:0] s;
    s = '0;
    repeat (n) s[$urandom_range(lo, hi)] = 1'b1;
    return s;
  endfunction

  // Every data field random; the caller then sets the request code it wants.
  function automatic rlso_pkg::req_item_t noise_item();
    rlso_pkg::req_item_t it;
    it.req_type = rlso_pkg::REQ_OPT;
    {it.set_a_high, it.set_a_low} = random_set();
    {it.set_b_high, it.set_b_low} = random_set();
    it.row_index    = 7'($urandom);
    it.split_slot   = 4'($urandom);
    it.prefix_index = 7'($urandom);
    it.suffix_index = 7'($urandom);
    return it;
  endfunction

  // Split parts are usually shorter infixes than the row itself.
  function automatic bit [6:0] split_part(int unsigned row);
    if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, (row < 2) ? 1 : row - 1));
  endfunction

  // Builds a load for a row, either appending the next slot or picking any
  // slot that keeps the written run unbroken.
  function automatic rlso_pkg::req_item_t random_load(int unsigned row, bit append);
    rlso_pkg::req_item_t it;
    int unsigned         top;
    it = noise_item();
    it.req_type  = rlso_pkg::REQ_LOAD;
    it.row_index = 7'(row);
    top = (slots_filled[row] < NUM_SLOTS) ? slots_filled[row] : NUM_SLOTS - 1;
    it.split_slot = 4'((append && slots_filled[row] < NUM_SLOTS) ? top
                                                                  : $urandom_range(0, top));
    if (it.split_slot == slots_filled[row]) slots_filled[row]++;
    it.prefix_index = split_part(row);
    it.suffix_index = split_part(row);
    return it;
  endfunction

  function automatic rlso_pkg::req_item_t random_request();
    rlso_pkg::req_item_t it;
    int unsigned         pick;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 15)      it = random_load($urandom_range(0, NUM_ROWS - 1), 1'b0);
    else if (pick < 17) it.req_type = REQ_UNUSED_6;
    else if (pick < 19) it.req_type = REQ_UNUSED_7;
    else if (pick < 29) it.req_type = rlso_pkg::REQ_OPT;
    else if (pick < 56) it.req_type = rlso_pkg::REQ_STAR;
    else if (pick < 83) it.req_type = rlso_pkg::REQ_CAT;
    else if (pick < 92) it.req_type = rlso_pkg::REQ_UNION;
    else                it.req_type = rlso_pkg::REQ_INTER;
    return it;
  endfunction

  // Sends one item and returns at the edge where it transfers. start is left
  // high so that a following item goes out without a gap; it only drops in
  // an idle cycle or when the bench pauses.
  task automatic send_item(rlso_pkg::req_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_request(it);
  endtask

  task automatic send_op(logic [2:0] code, bit [127:0] a, bit [127:0] b);
    rlso_pkg::req_item_t it;
    it = noise_item();
    it.req_type = code;
    {it.set_a_high, it.set_a_low} = a;
    {it.set_b_high, it.set_b_low} = b;
    send_item(it);
  endtask

  // Directed load; the slot must not leave a hole in the row.
  task automatic load_split(int unsigned row, int unsigned slot, int unsigned pre,
                            int unsigned suf);
    rlso_pkg::req_item_t it;
    it = noise_item();
    it.req_type     = rlso_pkg::REQ_LOAD;
    it.row_index    = 7'(row);
    it.split_slot   = 4'(slot);
    it.prefix_index = 7'(pre);
    it.suffix_index = 7'(suf);
    if (slot == slots_filled[row]) slots_filled[row]++;
    send_item(it);
  endtask

  // Stops sending and waits until every predicted result has been seen, then
  // gives a trailing load or ignored request time to finish.
  task automatic wait_results_done();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; valid stays high so back-to-back writes need no gap.
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      rlso_pkg::CFG_ALPHABET_SIZE: cfg_alpha       = 32'(data[6:0]);
      rlso_pkg::CFG_INFIX_COUNT:   cfg_icount      = 32'(data[7:0]);
      rlso_pkg::CFG_POSITIVE_LOW:  cfg_pos[63:0]   = data;
      rlso_pkg::CFG_POSITIVE_HIGH: cfg_pos[127:64] = data;
      rlso_pkg::CFG_NEGATIVE_LOW:  cfg_neg[63:0]   = data;
      rlso_pkg::CFG_NEGATIVE_HIGH: cfg_neg[127:64] = data;
      default: ;
    endcase
  endtask

  // Writes every register. The bits above the two narrow registers carry
  // random junk, which the unit must drop.
  task automatic set_config(int unsigned alpha, int unsigned icount, bit [127:0] pos,
                            bit [127:0] neg);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(rlso_pkg::CFG_ALPHABET_SIZE, {junk[63:7], 7'(alpha)});
    write_reg(rlso_pkg::CFG_INFIX_COUNT,   {junk[63:8], 8'(icount)});
    write_reg(rlso_pkg::CFG_POSITIVE_LOW,  pos[63:0]);
    write_reg(rlso_pkg::CFG_POSITIVE_HIGH, pos[127:64]);
    write_reg(rlso_pkg::CFG_NEGATIVE_LOW,  neg[63:0]);
    write_reg(rlso_pkg::CFG_NEGATIVE_HIGH, neg[127:64]);
    cfg_valid_i <= 1'b0;
  endtask

  // Settles the unit, applies one setting, then sends random traffic.
  task automatic run_phase(int unsigned alpha, int unsigned icount, bit [127:0] pos,
                           bit [127:0] neg, int unsigned count);
    wait_results_done();
    set_config(alpha, icount, pos, neg);
    repeat (count) send_item(random_request());
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Field extremes, every operation, the empty word on either side of a
  // concatenation, and both unused request codes.
  task automatic test_directed_cases();
    wait_results_done();
    set_config(2, 128, '0, '0);
    load_split(5, 0, 1, 2);
    load_split(0, 0, 0, 0);         // row 0 is never walked
    load_split(127, 0, 127, 127);   // top row, top indices
    send_op(rlso_pkg::REQ_OPT, '0, '0);
    send_op(rlso_pkg::REQ_OPT, '1, '1);
    send_op(rlso_pkg::REQ_UNION, '0, '1);
    send_op(rlso_pkg::REQ_UNION, '0, '0);
    send_op(rlso_pkg::REQ_INTER, '1, '1);
    send_op(rlso_pkg::REQ_INTER, '1, '0);
    send_op(rlso_pkg::REQ_STAR, 128'h6, '0);  // singles 1 and 2 join into row 5
    send_op(rlso_pkg::REQ_STAR, '0, '1);
    send_op(rlso_pkg::REQ_STAR, '1, '0);
    send_op(rlso_pkg::REQ_CAT, 128'h2, 128'h4);
    send_op(rlso_pkg::REQ_CAT, 128'h3, 128'h4);
    send_op(rlso_pkg::REQ_CAT, 128'h2, 128'h5);
    send_op(rlso_pkg::REQ_CAT, '1, '1);
    send_op(rlso_pkg::REQ_CAT, '0, '0);
    send_op(REQ_UNUSED_6, '1, '1);
    send_op(REQ_UNUSED_7, '1, '0);
    send_op(rlso_pkg::REQ_OPT, 128'h2, '0);   // nothing changed by the ignored codes
    load_split(5, 0, 2, 1);                   // overwrite flips which order joins
    send_op(rlso_pkg::REQ_CAT, 128'h2, 128'h4);
  endtask

  // Fills the guide table row by row with unbroken slot runs; a few rows get
  // all sixteen slots.
  task automatic test_split_table_build();
    int unsigned n;
    for (int unsigned row = 0; row < NUM_ROWS; row++) begin
      n = (row % 32 == 31) ? NUM_SLOTS : $urandom_range(0, 2);
      repeat (n) send_item(random_load(row, 1'b1));
    end
  endtask

  // Walk range limits: full walk, nothing walked, an oversized infix count,
  // a zero infix count, only the top row, and a random partial range. The
  // example sets go to their extremes here.
  task automatic test_walk_bounds();
    run_phase(0, 128, '0, '0, 40);
    run_phase(127, 128, '1, '1, 40);
    run_phase(3, 200, '0, '1, 40);
    run_phase($urandom_range(0, 127), 0, random_set(), random_set(), 40);
    run_phase(126, 128, '1, '0, 40);
    run_phase(1, $urandom_range(2, 128), '0, '0, 40);
  endtask

  // Sparse positive and negative sets so the fit flags take both values. The
  // sender also holds off once until every outstanding result is back.
  task automatic test_example_flags();
    run_phase(2, 64, sparse_bits(0, 8, 2), sparse_bits(40, 127, 3), 50);
    wait_results_done();
    repeat (40) send_item(random_request());
    run_phase(4, 128, sparse_bits(1, 4, 1), sparse_bits(10, 127, 2), 40);
  endtask

  // A long stretch with no sender gaps, so items start in the very cycle a
  // result is shown.
  task automatic test_back_to_back();
    idle_pct = 0;
    run_phase(2, 128, '0, '0, 80);
    idle_pct = 11;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= rlso_pkg::CFG_ALPHABET_SIZE;
    cfg_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_split_table_build();
    test_walk_bounds();
    test_example_flags();
    test_back_to_back();

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("PASS regex_language_set_ops_unit");
    end else begin
      $display("FAIL regex_language_set_ops_unit");
    end
    $finish;
  end

endmodule
